### src/ppcs_pkg.sv
// Package for the pulse repetition interval chain search block.
// Holds widths, default parameters, register indexes and the control/status structs.
// No dependencies.
package ppcs_pkg;

    localparam int WINDOW_DEF          = 128;
    localparam int MAX_HARMONIC_DEF    = 2;
    localparam int FREQ_DIFF_LIMIT_DEF = 200;
    localparam int DIR_DIFF_LIMIT_DEF  = 10;

    localparam int TIME_W  = 32;
    localparam int CODE_W  = 16;
    localparam int IVL_W   = 24;
    localparam int CHAIN_W = 16;
    localparam int CFG_IDX_W = 3;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQ_LOW      = 3'd0,
        CFG_FREQ_HIGH     = 3'd1,
        CFG_DIR_LOW       = 3'd2,
        CFG_DIR_HIGH      = 3'd3,
        CFG_WIDTH_LOW     = 3'd4,
        CFG_WIDTH_HIGH    = 3'd5,
        CFG_INTERVAL_LOW  = 3'd6,
        CFG_INTERVAL_HIGH = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [TIME_W-1:0]  time_val;
        logic [CODE_W-1:0]  freq;
        logic [CODE_W-1:0]  dir;
        logic               gate_ok;
        logic [CHAIN_W-1:0] chain;
    } t_entry;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } t_sts;

endpackage

### src/ppcs_ctrl.sv
// Sequencer for the chain search: accept, window scan, pipeline drain, commit.
// Depends on ppcs_pkg for the command and status structs.
module ppcs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ppcs_pkg::t_sts  i_sts,
    output ppcs_pkg::t_cmd  o_cmd
);
    import ppcs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = !i_sts.empty;
                if (i_sts.empty || i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_in_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> (r_state == S_IDLE))
        else $error("input ready outside idle");
    a_load_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_SCAN))
        else $error("accepted pulse did not start a scan");
    a_commit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> !o_cmd.commit && r_in_ready)
        else $error("commit not followed by idle");

endmodule

### src/ppcs_dp.sv
// Datapath for the chain search: config registers, pulse window memory,
// link test pipeline, best-chain accumulator and output register. Depends on ppcs_pkg.
module ppcs_dp #(
    parameter int WINDOW          = ppcs_pkg::WINDOW_DEF,
    parameter int MAX_HARMONIC    = ppcs_pkg::MAX_HARMONIC_DEF,
    parameter int FREQ_DIFF_LIMIT = ppcs_pkg::FREQ_DIFF_LIMIT_DEF,
    parameter int DIR_DIFF_LIMIT  = ppcs_pkg::DIR_DIFF_LIMIT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ppcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppcs_pkg::IVL_W-1:0]     i_cfg_data,
    input  logic                           i_start,
    input  logic [ppcs_pkg::TIME_W-1:0]    i_time,
    input  logic [ppcs_pkg::CODE_W-1:0]    i_freq,
    input  logic [ppcs_pkg::CODE_W-1:0]    i_dir,
    input  logic [ppcs_pkg::CODE_W-1:0]    i_width,
    input  ppcs_pkg::t_cmd                 i_cmd,
    output ppcs_pkg::t_sts                 o_sts,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [ppcs_pkg::CHAIN_W-1:0]   o_chain_length,
    output logic                           o_has_link
);
    import ppcs_pkg::*;

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);
    localparam int HW = IVL_W + $clog2(MAX_HARMONIC + 1);
    localparam logic [CODE_W-1:0]  FREQ_LIM  = CODE_W'(FREQ_DIFF_LIMIT);
    localparam logic [CODE_W-1:0]  DIR_LIM   = CODE_W'(DIR_DIFF_LIMIT);
    localparam logic [CHAIN_W-1:0] CHAIN_MAX = '1;

    logic [CODE_W-1:0] r_freq_low, r_freq_high, r_dir_low, r_dir_high;
    logic [CODE_W-1:0] r_width_low, r_width_high;
    logic [IVL_W-1:0]  r_ivl_low, r_ivl_high;

    logic [HW-1:0]      r_lo_h [MAX_HARMONIC];
    logic [HW-1:0]      r_hi_h [MAX_HARMONIC];
    logic [TIME_W-1:0]  r_time;
    logic [CODE_W-1:0]  r_freq;
    logic [CODE_W-1:0]  r_dir;
    logic               r_gate;

    t_entry             r_mem [WINDOW];
    t_entry             r_rd_data;
    logic               r_rd_v;
    logic [AW-1:0]      r_rd_addr;
    logic [AW-1:0]      r_wslot;
    logic [CW-1:0]      r_fill;

    logic               r_cand_v;
    logic               r_cand_link;
    logic [CHAIN_W-1:0] r_cand_c;
    logic [CHAIN_W-1:0] r_best;
    logic               r_link;

    logic               r_out_v;
    logic [CHAIN_W-1:0] r_out_chain;
    logic               r_out_link;

    logic [TIME_W-1:0]  dt;
    logic [CODE_W-1:0]  fdiff;
    logic [CODE_W-1:0]  ddiff;
    logic               ivl_hit;
    logic               link;
    logic [CHAIN_W-1:0] c_base;
    logic [CHAIN_W-1:0] c_next;
    logic               gate;
    t_entry             wr_entry;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_low   <= '0;
            r_freq_high  <= '1;
            r_dir_low    <= '0;
            r_dir_high   <= '1;
            r_width_low  <= '0;
            r_width_high <= '1;
            r_ivl_low    <= '0;
            r_ivl_high   <= '1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FREQ_LOW:      r_freq_low   <= i_cfg_data[CODE_W-1:0];
                CFG_FREQ_HIGH:     r_freq_high  <= i_cfg_data[CODE_W-1:0];
                CFG_DIR_LOW:       r_dir_low    <= i_cfg_data[CODE_W-1:0];
                CFG_DIR_HIGH:      r_dir_high   <= i_cfg_data[CODE_W-1:0];
                CFG_WIDTH_LOW:     r_width_low  <= i_cfg_data[CODE_W-1:0];
                CFG_WIDTH_HIGH:    r_width_high <= i_cfg_data[CODE_W-1:0];
                CFG_INTERVAL_LOW:  r_ivl_low    <= i_cfg_data;
                CFG_INTERVAL_HIGH: r_ivl_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign gate = (i_freq  >= r_freq_low)  && (i_freq  <= r_freq_high) &&
                  (i_dir   >= r_dir_low)   && (i_dir   <= r_dir_high)  &&
                  (i_width >= r_width_low) && (i_width <= r_width_high);

    // hold the pulse and the harmonic interval bounds for the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_time <= i_time;
            r_freq <= i_freq;
            r_dir  <= i_dir;
            r_gate <= gate;
            for (int j = 0; j < MAX_HARMONIC; j++) begin
                r_lo_h[j] <= HW'(r_ivl_low)  * HW'(j + 1);
                r_hi_h[j] <= HW'(r_ivl_high) * HW'(j + 1);
            end
        end
    end

    assign wr_entry = '{time_val: r_time, freq: r_freq, dir: r_dir,
                        gate_ok: r_gate, chain: r_best};

    // window memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_mem[r_wslot] <= wr_entry;
        end
        if (i_cmd.scan_rd) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    // link test
    always_comb begin
        dt      = r_time - r_rd_data.time_val;
        fdiff   = (r_rd_data.freq > r_freq) ? r_rd_data.freq - r_freq
                                            : r_freq - r_rd_data.freq;
        ddiff   = (r_rd_data.dir > r_dir) ? r_rd_data.dir - r_dir
                                          : r_dir - r_rd_data.dir;
        ivl_hit = 1'b0;
        for (int j = 0; j < MAX_HARMONIC; j++) begin
            if (dt >= TIME_W'(r_lo_h[j]) && dt <= TIME_W'(r_hi_h[j])) begin
                ivl_hit = 1'b1;
            end
        end
        link   = r_rd_data.gate_ok && (fdiff <= FREQ_LIM) && (ddiff <= DIR_LIM) && ivl_hit;
        c_base = (r_rd_data.chain == '0) ? CHAIN_W'(1) : r_rd_data.chain;
        c_next = (c_base == CHAIN_MAX) ? CHAIN_MAX : c_base + CHAIN_W'(1);
    end

    // control registers: window bookkeeping, pipeline valids, accumulator, output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_wslot   <= '0;
            r_rd_addr <= '0;
            r_rd_v    <= 1'b0;
            r_cand_v  <= 1'b0;
            r_out_v   <= 1'b0;
            r_best    <= '0;
            r_link    <= 1'b0;
        end else begin
            r_rd_v   <= i_cmd.scan_rd;
            r_cand_v <= r_rd_v;
            if (i_cmd.load) begin
                r_rd_addr <= '0;
                r_best    <= '0;
                r_link    <= 1'b0;
                if (i_start) begin
                    r_fill  <= '0;
                    r_wslot <= '0;
                end
            end else begin
                if (i_cmd.scan_rd) begin
                    r_rd_addr <= r_rd_addr + AW'(1);
                end
                if (r_cand_v && r_cand_link) begin
                    r_link <= 1'b1;
                    if (r_cand_c > r_best) begin
                        r_best <= r_cand_c;
                    end
                end
            end
            if (i_cmd.commit) begin
                r_wslot <= (r_wslot == AW'(WINDOW - 1)) ? '0 : r_wslot + AW'(1);
                if (r_fill != CW'(WINDOW)) begin
                    r_fill <= r_fill + CW'(1);
                end
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand_link <= link;
        r_cand_c    <= c_next;
        if (i_cmd.commit) begin
            r_out_chain <= r_best;
            r_out_link  <= r_link;
        end
    end

    assign o_sts.empty     = (r_fill == '0);
    assign o_sts.scan_last = ((CW'(r_rd_addr) + CW'(1)) == r_fill);
    assign o_sts.pipe_busy = r_rd_v || r_cand_v;
    assign o_sts.out_free  = !r_out_v || i_out_ready;

    assign o_out_valid    = r_out_v;
    assign o_chain_length = r_out_chain;
    assign o_has_link     = r_out_link;

    a_read_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_rd |-> (CW'(r_rd_addr) < r_fill))
        else $error("window read beyond filled entries");
    a_commit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!o_sts.pipe_busy && o_sts.out_free))
        else $error("commit with pipeline busy or output blocked");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(WINDOW))
        else $error("fill count beyond window");
    a_link_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_link) |-> (r_out_chain >= CHAIN_W'(2)))
        else $error("linked result with chain below two");

endmodule

### src/pulse_pri_chain_search.sv
// Top level of the pulse repetition interval chain search.
// Instantiates ppcs_ctrl and ppcs_dp; depends on ppcs_pkg.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+------------------------------------------
//  s_axis    | s_axis_tvalid/s_axis_tready  | tdata: time, freq, dir, width; tuser: start
//  m_axis    | m_axis_tvalid/m_axis_tready  | tdata: chain_length; tuser: has_link
//  cfg       | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// The scan reads one window entry per cycle from the window memory, covering the fill stored pulses
// (at most WINDOW); with an empty window no entry is read.
// Reset clears the fill count, so no clearing pass is run.
// A waiting result stalls only the commit of the next pulse, not its acceptance or scan.
// Config writes are taken every cycle.
module pulse_pri_chain_search #(
    parameter int WINDOW          = ppcs_pkg::WINDOW_DEF,
    parameter int MAX_HARMONIC    = ppcs_pkg::MAX_HARMONIC_DEF,
    parameter int FREQ_DIFF_LIMIT = ppcs_pkg::FREQ_DIFF_LIMIT_DEF,
    parameter int DIR_DIFF_LIMIT  = ppcs_pkg::DIR_DIFF_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] arrival_time, [47:32] freq_code, [63:48] dir_code, [79:64] width_code
    input  logic [ppcs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] start_batch
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] chain_length
    output logic [ppcs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] has_link
    output logic                            m_axis_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ppcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ppcs_pkg::IVL_W-1:0]      i_cfg_data
);
    import ppcs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    ppcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ppcs_dp #(
        .WINDOW          (WINDOW),
        .MAX_HARMONIC    (MAX_HARMONIC),
        .FREQ_DIFF_LIMIT (FREQ_DIFF_LIMIT),
        .DIR_DIFF_LIMIT  (DIR_DIFF_LIMIT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_start        (s_axis_tuser),
        .i_time         (s_axis_tdata[31:0]),
        .i_freq         (s_axis_tdata[47:32]),
        .i_dir          (s_axis_tdata[63:48]),
        .i_width        (s_axis_tdata[79:64]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_chain_length (m_axis_tdata),
        .o_has_link     (m_axis_tuser)
    );

endmodule
